FILE: hw/rtl/ppmfg_pkg.sv
package ppmfg_pkg;

   localparam int FRAME_W = 16;
   localparam int US_W    = 12;
   localparam int ELAPSED_W = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int SLOT_OUT_W  = 4;

   localparam logic [FRAME_W-1:0]   RESET_FRAME_LENGTH = 16'd20000;
   localparam logic [US_W-1:0]      RESET_PULSE_LENGTH = 12'd400;
   localparam logic [US_W-1:0]      RESET_SLOT_MINIMUM = 12'd800;
   localparam logic [US_W-1:0]      RESET_SLOT_MAXIMUM = 12'd2200;
   localparam logic [US_W-1:0]      RESET_WIDTH        = 12'd1000;
   localparam logic [ELAPSED_W-1:0] FRAME_MAX          = 17'h1FFFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_MINIMUM = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_MAXIMUM = 2'd3;

   localparam logic COMMAND_TICK  = 1'b0;
   localparam logic COMMAND_WRITE = 1'b1;

   typedef struct packed {
      logic                  line_level;
      logic                  frame_begin;
      logic                  frame_overrun;
      logic [SLOT_OUT_W-1:0] slot_now;
   } rsp_type;

endpackage

FILE: hw/rtl/ppmfg_req_if.sv
interface ppmfg_req_if;
   import ppmfg_pkg::*;

   logic            valid;
   logic            ready;
   logic            command;
   logic [2:0]      channel_index;
   logic [US_W-1:0] channel_width_us;

   modport source (output valid, command, channel_index, channel_width_us, input ready);
   modport sink   (input valid, command, channel_index, channel_width_us, output ready);
endinterface

FILE: hw/rtl/ppmfg_rsp_if.sv
interface ppmfg_rsp_if;
   import ppmfg_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  line_level;
   logic                  frame_begin;
   logic                  frame_overrun;
   logic [SLOT_OUT_W-1:0] slot_now;

   modport source (output valid, line_level, frame_begin, frame_overrun, slot_now,
                   input ready);
   modport sink   (input valid, line_level, frame_begin, frame_overrun, slot_now,
                   output ready);
endinterface

FILE: hw/rtl/ppmfg_out_skid.sv
module ppmfg_out_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ppmfg_pkg::rsp_type  in_data,
   output logic                in_ready,
   output logic                out_valid,
   output ppmfg_pkg::rsp_type  out_data,
   input  logic                out_ready
);
   import ppmfg_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid && !skid_valid_ff) begin
         // output stalled: park the new result
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

FILE: hw/rtl/ppm_frame_generator_top.sv
// PPM frame generator
// req_if carries requests: a tick (command 0) advances the pulse train by one
// microsecond and yields one response; a write (command 1) stores the width of
// channel channel_index and yields no response. rsp_if gives the line level,
// the frame start and overrun flags and the current slot (CHANNELS in the gap).
// The csr_ port sets frame length, separator pulse length and the clamp bounds;
// write it only while the block is idle.
// A tick's response is registered in the output stage. Throughput: one request
// per cycle while req_if.ready is high; all slot and frame counters update
// together from the registered state, so the counter compare path sets it.
// A two-entry output stage (register plus skid) lets one more request in while
// a response waits; with both entries full req_if.ready drops until rsp_if
// takes a response. Nothing is lost or reordered under stalls.
// Reset (synchronous, active high) restores the register defaults, sets every
// channel width to 1000, empties the output stage and makes the first tick
// begin a new frame.
module ppm_frame_generator_top #(
   parameter int CHANNELS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   ppmfg_req_if.sink                           req_if,
   ppmfg_rsp_if.source                         rsp_if,
   input  logic                                csr_write_enable,
   input  logic [ppmfg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ppmfg_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import ppmfg_pkg::*;

   localparam int SLOT_W = $clog2(CHANNELS + 1);
   localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [SLOT_W-1:0] SLOT_GAP = SLOT_W'(CHANNELS);

   logic [FRAME_W-1:0] frame_length_ff;
   logic [US_W-1:0]    pulse_length_ff;
   logic [US_W-1:0]    slot_minimum_ff;
   logic [US_W-1:0]    slot_maximum_ff;

   logic [US_W-1:0]      widths_ff [CHANNELS];
   logic [SLOT_W-1:0]    slot_index_ff, slot_index_in;
   logic [US_W-1:0]      slot_elapsed_ff, slot_elapsed_in;
   logic [US_W-1:0]      slot_length_ff, slot_length_in;
   logic [ELAPSED_W-1:0] frame_elapsed_ff, frame_elapsed_in;
   logic                 overrun_ff, overrun_in;

   logic          accept, tick, wr, in_ready;
   logic [31:0]   ch_ext;
   logic [IDX_W-1:0] wr_idx, rd_idx;
   logic          in_gap, slot_start, slot_end, frame_done;
   logic [US_W-1:0] w_raw, w_lo, w_hi, w_len, len;
   logic [US_W:0]   elapsed_inc;
   logic [ELAPSED_W-1:0] frame_bump;
   logic [SLOT_W-1:0]    slot_next;
   logic [31:0]   slot_ext;
   rsp_type       res, out_data;
   logic          out_valid;

   assign accept = req_if.valid && in_ready;
   assign tick   = accept && (req_if.command == COMMAND_TICK);
   assign wr     = accept && (req_if.command == COMMAND_WRITE);
   assign req_if.ready = in_ready;

   assign ch_ext = 32'(req_if.channel_index);
   assign wr_idx = ch_ext[IDX_W-1:0];

   always_comb begin
      in_gap     = slot_index_ff >= SLOT_GAP;
      rd_idx     = in_gap ? '0 : slot_index_ff[IDX_W-1:0];
      w_raw      = widths_ff[rd_idx];
      // clamp order matters: minimum, then maximum, then at least the pulse
      w_lo       = (w_raw < slot_minimum_ff) ? slot_minimum_ff : w_raw;
      w_hi       = (w_lo > slot_maximum_ff) ? slot_maximum_ff : w_lo;
      w_len      = (w_hi < pulse_length_ff) ? pulse_length_ff : w_hi;
      slot_start = slot_elapsed_ff == '0;
      len        = slot_start ? w_len : slot_length_ff;
      elapsed_inc = {1'b0, slot_elapsed_ff} + 1'b1;
      slot_end   = elapsed_inc >= {1'b0, len};
      frame_bump = (frame_elapsed_ff == FRAME_MAX) ? frame_elapsed_ff
                                                   : frame_elapsed_ff + 1'b1;
      frame_done = frame_bump >= {1'b0, frame_length_ff};
      slot_next  = slot_index_ff + 1'b1;
      slot_ext   = 32'(slot_index_ff);

      slot_index_in    = slot_index_ff;
      slot_elapsed_in  = slot_elapsed_ff;
      slot_length_in   = slot_length_ff;
      frame_elapsed_in = frame_bump;
      overrun_in       = overrun_ff;

      res.line_level    = 1'b1;
      res.frame_begin   = 1'b0;
      res.frame_overrun = 1'b0;
      res.slot_now      = SLOT_OUT_W'(CHANNELS);

      if (in_gap) begin
         if (frame_done) begin
            slot_index_in    = '0;
            slot_elapsed_in  = '0;
            frame_elapsed_in = '0;
         end
      end else begin
         res.slot_now   = slot_ext[SLOT_OUT_W-1:0];
         res.line_level = !(slot_elapsed_ff < pulse_length_ff);
         slot_length_in = len;
         if (slot_start && (slot_index_ff == '0)) begin
            res.frame_begin   = 1'b1;
            res.frame_overrun = overrun_ff;
            overrun_in        = 1'b0;
         end
         if (slot_end) begin
            slot_elapsed_in = '0;
            slot_index_in   = slot_next;
            // channels reached the frame length: no sync gap
            if ((slot_next >= SLOT_GAP) && frame_done) begin
               overrun_in       = 1'b1;
               slot_index_in    = '0;
               frame_elapsed_in = '0;
            end
         end else begin
            slot_elapsed_in = elapsed_inc[US_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_index_ff    <= '0;
         slot_elapsed_ff  <= '0;
         slot_length_ff   <= '0;
         frame_elapsed_ff <= '0;
         overrun_ff       <= 1'b0;
      end else if (tick) begin
         slot_index_ff    <= slot_index_in;
         slot_elapsed_ff  <= slot_elapsed_in;
         slot_length_ff   <= slot_length_in;
         frame_elapsed_ff <= frame_elapsed_in;
         overrun_ff       <= overrun_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            widths_ff[i] <= RESET_WIDTH;
         end
      end else if (wr && (ch_ext < 32'(CHANNELS))) begin
         widths_ff[wr_idx] <= req_if.channel_width_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= RESET_FRAME_LENGTH;
         pulse_length_ff <= RESET_PULSE_LENGTH;
         slot_minimum_ff <= RESET_SLOT_MINIMUM;
         slot_maximum_ff <= RESET_SLOT_MAXIMUM;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_LENGTH: frame_length_ff <= csr_write_data;
            CSR_PULSE_LENGTH: pulse_length_ff <= csr_write_data[US_W-1:0];
            CSR_SLOT_MINIMUM: slot_minimum_ff <= csr_write_data[US_W-1:0];
            CSR_SLOT_MAXIMUM: slot_maximum_ff <= csr_write_data[US_W-1:0];
            default: ;
         endcase
      end
   end

   ppmfg_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tick),
      .in_data   (res),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_data  (out_data),
      .out_ready (rsp_if.ready)
   );

   assign rsp_if.valid         = out_valid;
   assign rsp_if.line_level    = out_data.line_level;
   assign rsp_if.frame_begin   = out_data.frame_begin;
   assign rsp_if.frame_overrun = out_data.frame_overrun;
   assign rsp_if.slot_now      = out_data.slot_now;

endmodule

FILE: hw/rtl/ppmfg_checker.sv
module ppmfg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       line_level,
   input logic       frame_begin,
   input logic       frame_overrun,
   input logic [3:0] slot_now
);

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({line_level, frame_begin, frame_overrun, slot_now}))
      else $error("response changed while stalled");

   a_overrun_on_begin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_overrun |-> frame_begin)
      else $error("overrun flagged away from a frame start");

   a_begin_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_begin |-> slot_now == 4'd0)
      else $error("frame start outside the first slot");

   // the output stage is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("output stage not empty after reset");

   a_ready_with_space: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with an empty output stage");

endmodule

bind ppm_frame_generator_top ppmfg_checker u_ppmfg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .line_level    (rsp_if.line_level),
   .frame_begin   (rsp_if.frame_begin),
   .frame_overrun (rsp_if.frame_overrun),
   .slot_now      (rsp_if.slot_now)
);

FILE: test/ppm_frame_generator_top_test.sv
`timescale 1ns / 1ps

module ppm_frame_generator_top_test;
   import ppmfg_pkg::*;

   localparam int CHANNELS      = 8;
   localparam int PHASE_ITEMS   = 45;
   localparam int RANDOM_PHASES = 13;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DIRECTED_ROWS = 16;
   localparam int PRESETS       = 6;

   typedef struct packed {
      logic            command;
      logic [2:0]      channel;
      logic [US_W-1:0] width;
      logic            pinned;
      rsp_type         rsp;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   ppmfg_req_if req_ch ();
   ppmfg_rsp_if rsp_ch ();

   ppm_frame_generator_top #(.CHANNELS(CHANNELS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // pulse train state as the block should hold it
   logic [US_W-1:0]       width_store [CHANNELS];
   logic [SLOT_OUT_W-1:0] slot_idx;
   logic [US_W-1:0]       slot_elapsed;
   logic [US_W-1:0]       slot_length;
   logic [ELAPSED_W-1:0]  frame_elapsed;
   logic                  overrun_pending;
   logic [FRAME_W-1:0]    frame_length;
   logic [US_W-1:0]       pulse_length;
   logic [US_W-1:0]       slot_minimum;
   logic [US_W-1:0]       slot_maximum;

   rsp_type      pending_tick_rsp [$];
   stim_row_type issued_rows [$];
   int      fault_count;
   int      cycle_count;
   int      stall_left;
   logic    calm_source;
   logic    calm_sink;

   // after reset, defaults: slot length 1000, pulse 400
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{COMMAND_TICK,  3'd0, 12'd0,    1'b1, '{1'b0, 1'b1, 1'b0, 4'd0}},
      '{COMMAND_TICK,  3'd0, 12'd0,    1'b1, '{1'b0, 1'b0, 1'b0, 4'd0}},
      '{COMMAND_WRITE, 3'd0, 12'd0,    1'b0, '0},
      '{COMMAND_WRITE, 3'd7, 12'd4095, 1'b0, '0},
      '{COMMAND_TICK,  3'd7, 12'd4095, 1'b0, '0},
      '{COMMAND_WRITE, 3'd5, 12'hAAA,  1'b0, '0},
      '{COMMAND_WRITE, 3'd2, 12'h555,  1'b0, '0},
      '{COMMAND_TICK,  3'd0, 12'd0,    1'b0, '0},
      '{COMMAND_WRITE, 3'd1, 12'd4000, 1'b0, '0},
      '{COMMAND_WRITE, 3'd3, 12'd800,  1'b0, '0},
      '{COMMAND_WRITE, 3'd4, 12'd2200, 1'b0, '0},
      '{COMMAND_WRITE, 3'd6, 12'd1,    1'b0, '0},
      '{COMMAND_TICK,  3'd5, 12'hAAA,  1'b0, '0},
      '{COMMAND_TICK,  3'd2, 12'h555,  1'b0, '0},
      '{COMMAND_WRITE, 3'd0, 12'd3,    1'b0, '0},
      '{COMMAND_TICK,  3'd0, 12'd0,    1'b0, '0}
   };

   // frame, pulse, minimum, maximum
   logic [CSR_DATA_W-1:0] preset_regs [PRESETS][4] = '{
      '{16'd16,  16'd1, 16'd2,  16'd2},   // channels end exactly on the frame length
      '{16'd40,  16'd1, 16'd10, 16'd3},   // minimum above maximum
      '{16'd5,   16'd0, 16'd0,  16'd0},   // zero length slots, no low pulse
      '{16'd0,   16'd2, 16'd1,  16'd3},   // zero frame length
      '{16'd300, 16'd1, 16'd0,  16'd2},   // long sync gap
      '{16'd3,   16'd1, 16'd0,  16'd2}    // frame shortened while in the gap
   };

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_pause();
      if ($urandom_range(0, 99) < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic rsp_type advance_pulse_train();
      rsp_type r;
      logic [US_W-1:0] w;
      r = '0;
      r.line_level = 1'b1;
      if (slot_idx < SLOT_OUT_W'(CHANNELS)) begin
         r.slot_now = slot_idx;
         if (slot_elapsed == '0) begin
            w = width_store[slot_idx[2:0]];
            if (w < slot_minimum) w = slot_minimum;
            if (w > slot_maximum) w = slot_maximum;
            if (w < pulse_length) w = pulse_length;
            slot_length = w;
            if (slot_idx == '0) begin
               r.frame_begin = 1'b1;
               r.frame_overrun = overrun_pending;
               overrun_pending = 1'b0;
            end
         end
         r.line_level = (slot_elapsed < pulse_length) ? 1'b0 : 1'b1;
         slot_elapsed = slot_elapsed + 1'b1;
         if (frame_elapsed < FRAME_MAX) frame_elapsed = frame_elapsed + 1'b1;
         if (slot_elapsed >= slot_length) begin
            slot_elapsed = '0;
            slot_idx = slot_idx + 1'b1;
            if (slot_idx >= SLOT_OUT_W'(CHANNELS) &&
                frame_elapsed >= ELAPSED_W'(frame_length)) begin
               overrun_pending = 1'b1;
               slot_idx = '0;
               frame_elapsed = '0;
            end
         end
      end else begin
         r.slot_now = SLOT_OUT_W'(CHANNELS);
         if (frame_elapsed < FRAME_MAX) frame_elapsed = frame_elapsed + 1'b1;
         if (frame_elapsed >= ELAPSED_W'(frame_length)) begin
            slot_idx = '0;
            slot_elapsed = '0;
            frame_elapsed = '0;
         end
      end
      return r;
   endfunction

   // predictor follows accepted requests; checker compares accepted responses
   always @(posedge clock) begin
      stim_row_type row;
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            row = issued_rows.pop_front();
            if (req_ch.command == COMMAND_WRITE) begin
               width_store[req_ch.channel_index] = req_ch.channel_width_us;
            end else begin
               want = advance_pulse_train();
               if (row.pinned) want = row.rsp;
               pending_tick_rsp.push_back(want);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.line_level, rsp_ch.frame_begin, rsp_ch.frame_overrun,
                   rsp_ch.slot_now};
            if (pending_tick_rsp.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected response: level %0d begin %0d overrun %0d slot %0d",
                           got.line_level, got.frame_begin, got.frame_overrun,
                           got.slot_now);
            end else begin
               want = pending_tick_rsp.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"mismatch: expected level %0d begin %0d overrun %0d slot %0d,",
                               " got level %0d begin %0d overrun %0d slot %0d"},
                              want.line_level, want.frame_begin, want.frame_overrun,
                              want.slot_now, got.line_level, got.frame_begin,
                              got.frame_overrun, got.slot_now);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!calm_sink && $urandom_range(0, 99) < 25) begin
         stall_left = pick_pause() - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_request(input stim_row_type row);
      int gap;
      gap = 0;
      if (!calm_source && $urandom_range(0, 99) >= 55) gap = pick_pause();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      issued_rows.push_back(row);
      req_ch.valid            <= 1'b1;
      req_ch.command          <= row.command;
      req_ch.channel_index    <= row.channel;
      req_ch.channel_width_us <= row.width;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic wait_until_quiet();
      req_ch.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_tick_rsp.size() != 0) @(posedge clock);
      // a trailing write produces no response, give it time to land
      repeat (4) @(posedge clock);
   endtask

   task automatic program_registers(input logic [CSR_DATA_W-1:0] frame, pulse, minimum,
                                    maximum);
      frame_length = frame;
      pulse_length = pulse[US_W-1:0];
      slot_minimum = minimum[US_W-1:0];
      slot_maximum = maximum[US_W-1:0];
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FRAME_LENGTH;
      csr_write_data   <= frame;
      @(posedge clock);
      csr_index      <= CSR_PULSE_LENGTH;
      csr_write_data <= pulse;
      @(posedge clock);
      csr_index      <= CSR_SLOT_MINIMUM;
      csr_write_data <= minimum;
      @(posedge clock);
      csr_index      <= CSR_SLOT_MAXIMUM;
      csr_write_data <= maximum;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] frame, pulse, minimum, maximum);
      stim_row_type row;
      wait_until_quiet();
      program_registers(frame, pulse, minimum, maximum);
      calm_source = ($urandom_range(0, 3) == 0);
      calm_sink   = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         row = '0;
         if ($urandom_range(0, 99) < 22) begin
            row.command = COMMAND_WRITE;
            row.channel = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < 3)
               row.width = US_W'($urandom_range(0, 4095));
            else
               row.width = US_W'($urandom_range(0, 15));
         end else begin
            // fields are ignored on a tick, fill them anyway
            row.command = COMMAND_TICK;
            row.channel = 3'($urandom);
            row.width   = US_W'($urandom);
         end
         send_request(row);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] frame;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = COMMAND_TICK;
      req_ch.channel_index = '0;
      req_ch.channel_width_us = '0;
      rsp_ch.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_FRAME_LENGTH;
      csr_write_data = '0;
      fault_count = 0;
      cycle_count = 0;
      stall_left = 0;
      calm_source = 1'b0;
      calm_sink = 1'b0;
      for (int i = 0; i < CHANNELS; i++) width_store[i] = RESET_WIDTH;
      slot_idx = '0;
      slot_elapsed = '0;
      slot_length = '0;
      frame_elapsed = '0;
      overrun_pending = 1'b0;
      frame_length = RESET_FRAME_LENGTH;
      pulse_length = RESET_PULSE_LENGTH;
      slot_minimum = RESET_SLOT_MINIMUM;
      slot_maximum = RESET_SLOT_MAXIMUM;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) send_request(directed_rows[i]);

      for (int p = 0; p < PRESETS; p++)
         run_phase(preset_regs[p][0], preset_regs[p][1], preset_regs[p][2],
                   preset_regs[p][3]);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if ($urandom_range(0, 99) < 10)
            frame = CSR_DATA_W'($urandom_range(0, 65535));
         else
            frame = CSR_DATA_W'($urandom_range(0, 150));
         // upper data bits land outside the 12 bit registers
         run_phase(frame,
                   {4'($urandom), US_W'($urandom_range(0, 4))},
                   {4'($urandom), US_W'($urandom_range(0, 10))},
                   {4'($urandom), US_W'($urandom_range(0, 12))});
      end

      // widest settings last, their long slots would stall later phases
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

      wait_until_quiet();
      if (fault_count == 0 && pending_tick_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
